FILE: sv/particle_update_engine_top_macros.svh
// Assertion helpers shared by the particle update engine.
`ifndef PARTICLE_UPDATE_ENGINE_TOP_MACROS_SVH
`define PARTICLE_UPDATE_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PUE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define PUE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/pue_pkg.sv
package pue_pkg;

  localparam int PARTICLE_COUNT_DEF = 64;
  localparam int PIPE_DEPTH = 5;
  localparam int FRAC_BITS = 16;
  localparam int ALPHA_SHIFT = 6;
  localparam logic [7:0] ALPHA_MAX = 8'd255;

  localparam logic REQ_SPAWN = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [1:0] {
    CFG_DRAG    = 2'd0,
    CFG_GRAVITY = 2'd1,
    CFG_RENDER  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [30:0] time_value;
    logic [23:0] tile_number;
    logic [31:0] size_start;
    logic [31:0] size_rate;
    logic [31:0] angle_start;
    logic [31:0] angle_rate;
    logic [31:0] user_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sprite_left;
    logic [31:0] sprite_top;
    logic [31:0] sprite_size;
    logic [31:0] sprite_angle;
    logic [7:0]  sprite_mode;
    logic [23:0] sprite_tile;
    logic [7:0]  sprite_alpha;
    logic [31:0] sprite_tag;
    logic        last_record;
  } out_item_t;

  typedef struct packed {
    logic [31:0] life;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] size_now;
    logic [31:0] size_delta;
    logic [31:0] angle_now;
    logic [31:0] angle_delta;
    logic [23:0] tile;
    logic [31:0] tag;
  } part_t;

  typedef struct packed {
    logic  valid;
    part_t part;
  } pipe_out_t;

  function automatic logic is_pos(input logic [31:0] v);
    return (v != 32'd0) && !v[31];
  endfunction

  function automatic logic [31:0] asr16(input logic [31:0] v);
    return 32'($signed(v) >>> FRAC_BITS);
  endfunction

  function automatic logic [31:0] half_tz(input logic [31:0] v);
    logic [31:0] neg;
    neg = 32'd0 - v;
    return v[31] ? (32'd0 - (neg >> 1)) : (v >> 1);
  endfunction

endpackage

FILE: sv/pue_cell.sv
module pue_cell
  import pue_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  spawn_i,
  input  logic  step_i,
  input  part_t prev_i,
  input  part_t next_i,
  output part_t part_o
);

  part_t part_q;

  // spawn pushes towards the tail, a tick step pulls towards the head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
    end else if (spawn_i) begin
      part_q <= prev_i;
    end else if (step_i) begin
      part_q <= next_i;
    end
  end

  assign part_o = part_q;

endmodule

FILE: sv/pue_update.sv
module pue_update
  import pue_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  part_t       part_i,
  input  logic [30:0] t_i,
  input  logic [15:0] drag_i,
  input  logic [31:0] grav_i,
  output pipe_out_t   res_o
);

  typedef struct packed {
    logic        valid;
    logic        live;
    part_t       part;
    logic [31:0] mdx;
    logic [31:0] mdy;
    logic [31:0] mg;
    logic [31:0] ms;
    logic [31:0] ma;
  } st1_t;

  typedef struct packed {
    logic        valid;
    logic        live;
    part_t       part;
    logic [31:0] m2x;
    logic [31:0] m2y;
    logic [31:0] gt;
    logic [31:0] ds;
    logic [31:0] da;
  } st2_t;

  typedef struct packed {
    logic  valid;
    logic  live;
    part_t part;
  } st3_t;

  typedef struct packed {
    logic        valid;
    logic        live;
    part_t       part;
    logic [31:0] mpx;
    logic [31:0] mpy;
  } st4_t;

  st1_t      s1_q, s1_d;
  st2_t      s2_q, s2_d;
  st3_t      s3_q, s3_d;
  st4_t      s4_q, s4_d;
  pipe_out_t s5_q, s5_d;
  logic [31:0] t32;

  assign t32 = {1'b0, t_i};

  always_comb begin
    logic [31:0] l1;
    l1 = part_i.life - t32;
    s1_d       = '0;
    s1_d.valid = valid_i;
    s1_d.live  = is_pos(part_i.life) && is_pos(l1);
    s1_d.part  = part_i;
    s1_d.part.life = l1;
    s1_d.mdx   = part_i.vel_x * {16'd0, drag_i};
    s1_d.mdy   = part_i.vel_y * {16'd0, drag_i};
    s1_d.mg    = grav_i * t32;
    s1_d.ms    = part_i.size_delta * t32;
    s1_d.ma    = part_i.angle_delta * t32;
  end

  always_comb begin
    s2_d       = '0;
    s2_d.valid = s1_q.valid;
    s2_d.live  = s1_q.live;
    s2_d.part  = s1_q.part;
    s2_d.m2x   = asr16(s1_q.mdx) * t32;
    s2_d.m2y   = asr16(s1_q.mdy) * t32;
    s2_d.gt    = asr16(s1_q.mg);
    s2_d.ds    = asr16(s1_q.ms);
    s2_d.da    = asr16(s1_q.ma);
  end

  always_comb begin
    s3_d       = '0;
    s3_d.valid = s2_q.valid;
    s3_d.live  = s2_q.live;
    s3_d.part  = s2_q.part;
    s3_d.part.vel_x     = s2_q.part.vel_x - asr16(s2_q.m2x);
    s3_d.part.vel_y     = s2_q.part.vel_y - asr16(s2_q.m2y) + s2_q.gt;
    s3_d.part.size_now  = s2_q.part.size_now + s2_q.ds;
    s3_d.part.angle_now = s2_q.part.angle_now + s2_q.da;
  end

  always_comb begin
    s4_d       = '0;
    s4_d.valid = s3_q.valid;
    s4_d.live  = s3_q.live;
    s4_d.part  = s3_q.part;
    s4_d.mpx   = s3_q.part.vel_x * t32;
    s4_d.mpy   = s3_q.part.vel_y * t32;
  end

  // a dead particle keeps a life of zero; its other fields no longer matter
  always_comb begin
    s5_d       = '0;
    s5_d.valid = s4_q.valid;
    s5_d.part  = s4_q.part;
    s5_d.part.pos_x = s4_q.part.pos_x + asr16(s4_q.mpx);
    s5_d.part.pos_y = s4_q.part.pos_y + asr16(s4_q.mpy);
    s5_d.part.life  = (s4_q.live && is_pos(s4_q.part.size_now)) ? s4_q.part.life : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
      s5_q <= '0;
    end else if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
    end
  end

  assign res_o = s5_q;

endmodule

FILE: sv/particle_update_engine_top.sv
// Spawn: no result; the next item is taken in the following cycle.
// Tick: every particle passes once through the update pipeline, then the block flushes;
//   the first record is presented when the next live record arrives, otherwise at
//   the flush; an output stall holds the whole ring.
// Reset: every particle dead, ring position and configuration cleared.
module particle_update_engine_top
  import pue_pkg::*;
#(
  parameter int PARTICLE_COUNT = PARTICLE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  `include "particle_update_engine_top_macros.svh"

  localparam int LoopLen = PARTICLE_COUNT + PIPE_DEPTH;
  localparam int CntW = $clog2(LoopLen + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q;
  logic [30:0] t_q;
  logic [15:0] drag_q;
  logic [31:0] grav_q;
  logic [7:0]  mode_q;

  logic      in_acc, spawn, tick, out_free, step, flush_go, rec_live;
  part_t     spawn_part;
  part_t     ring [PARTICLE_COUNT];
  pipe_out_t tail;
  out_item_t rec, pend_q, out_q;
  logic      pend_valid_q, out_valid_q;

  // Configuration must only be written while the block is quiet; the block itself does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_q <= '0;
      grav_q <= '0;
      mode_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DRAG:    drag_q <= cfg_data_i[15:0];
        CFG_GRAVITY: grav_q <= cfg_data_i;
        CFG_RENDER:  mode_q <= cfg_data_i[7:0];
        default:     ;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign spawn      = in_acc && (in_item_i.req_type == REQ_SPAWN);
  assign tick       = in_acc && (in_item_i.req_type == REQ_TICK);

  // Advance the ring only when the output register has room for a record.
  assign out_free = !out_valid_q || !out_stall_i;
  assign step     = (state_q == ST_RUN) && out_free;
  assign flush_go = (state_q == ST_FLUSH) && out_free;

  always_comb begin
    spawn_part             = '0;
    spawn_part.life        = {1'b0, in_item_i.time_value};
    spawn_part.pos_x       = in_item_i.pos_x;
    spawn_part.pos_y       = in_item_i.pos_y;
    spawn_part.vel_x       = in_item_i.vel_x;
    spawn_part.vel_y       = in_item_i.vel_y;
    spawn_part.size_now    = in_item_i.size_start;
    spawn_part.size_delta  = in_item_i.size_rate;
    spawn_part.angle_now   = in_item_i.angle_start;
    spawn_part.angle_delta = in_item_i.angle_rate;
    spawn_part.tile        = in_item_i.tile_number;
    spawn_part.tag         = in_item_i.user_data;
  end

  // Head cell holds the newest particle, tail cell the oldest. A spawn shifts the
  // row tailwards and drops the oldest slot; a tick step pulls the row headwards
  // while the update pipeline closes the loop from head back to tail.
  for (genvar gi = 0; gi < PARTICLE_COUNT; gi++) begin : g_ring
    part_t prev_part, next_part;
    if (gi == 0) begin : g_head
      assign prev_part = spawn_part;
    end else begin : g_mid
      assign prev_part = ring[gi-1];
    end
    if (gi == PARTICLE_COUNT - 1) begin : g_tail
      assign next_part = tail.part;
    end else begin : g_body
      assign next_part = ring[gi+1];
    end
    pue_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .spawn_i(spawn),
      .step_i (step),
      .prev_i (prev_part),
      .next_i (next_part),
      .part_o (ring[gi])
    );
  end

  // Particles enter for the first PARTICLE_COUNT steps; bubbles fill the rest.
  pue_update u_update (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step),
    .valid_i(cnt_q < CntW'(PARTICLE_COUNT)),
    .part_i (ring[0]),
    .t_i    (t_q),
    .drag_i (drag_q),
    .grav_i (grav_q),
    .res_o  (tail)
  );

  // Build the record from the updated particle leaving the pipeline.
  always_comb begin
    logic [31:0] h;
    logic [25:0] sh;
    logic [7:0]  a8;
    h  = half_tz(tail.part.size_now);
    sh = tail.part.life[31:ALPHA_SHIFT];
    a8 = (|sh[25:8]) ? ALPHA_MAX : sh[7:0];
    rec              = '0;
    rec.sprite_left  = tail.part.pos_x - h;
    rec.sprite_top   = tail.part.pos_y - h;
    rec.sprite_size  = tail.part.size_now;
    rec.sprite_angle = tail.part.angle_now;
    rec.sprite_mode  = mode_q;
    rec.sprite_tile  = tail.part.tile;
    rec.sprite_alpha = ALPHA_MAX - a8;
    rec.sprite_tag   = tail.part.tag;
    rec.last_record  = 1'b0;
  end

  assign rec_live = tail.valid && is_pos(tail.part.life);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (tick) state_d = ST_RUN;
      ST_RUN:   if (step && (cnt_q == CntW'(LoopLen - 1))) state_d = ST_FLUSH;
      ST_FLUSH: if (flush_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (tick) begin
        cnt_q <= '0;
      end else if (step) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      t_q <= in_item_i.time_value;
    end
  end

  // Hold one record back so the final one of the list can be flagged.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (step && rec_live) begin
        pend_valid_q <= 1'b1;
      end else if (flush_go) begin
        pend_valid_q <= 1'b0;
      end
      if ((step && rec_live && pend_valid_q) || (flush_go && pend_valid_q)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The flag sits in the lowest bit of the record; set it on the flushed beat.
  always_ff @(posedge clk_i) begin
    if (step && rec_live) begin
      pend_q <= rec;
    end
    if (step && rec_live && pend_valid_q) begin
      out_q <= pend_q;
    end else if (flush_go && pend_valid_q) begin
      out_q <= {pend_q[$bits(out_item_t)-1:1], 1'b1};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `PUE_ASSERT_NEXT(a_tick_starts_run, tick, (state_q == ST_RUN) && (cnt_q == '0),
    "tick beat did not start a ring pass")
  `PUE_ASSERT_NOW(a_no_pend_idle, state_q == ST_IDLE, !pend_valid_q,
    "held record left behind after a tick")
  `PUE_ASSERT_NOW(a_pipe_fill, (state_q == ST_RUN) && (cnt_q < CntW'(PIPE_DEPTH)),
    !tail.valid, "pipeline delivered a particle before it could be filled")

endmodule
